// File: src/rrip_ship_cache_replacement_macros.svh
// assertion macros for the rrip replacement block
`ifndef RRIP_SHIP_CACHE_REPLACEMENT_MACROS_SVH
`define RRIP_SHIP_CACHE_REPLACEMENT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define RRIP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rrip assertion failed");
// expression must never be true outside reset
`define RRIP_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("rrip forbidden condition seen");
`else
`define RRIP_ASSERT(lbl, clk, rst, prop)
`define RRIP_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// File: src/rrip_pkg.sv
// shared types and constants of the rrip replacement block
package rrip_pkg;

  localparam int NUM_SETS      = 2048;
  localparam int SET_W         = 11;
  localparam int SIG_W         = 4;
  localparam int SIG_COUNT     = 1 << SIG_W;
  localparam int RRPV_W        = 2;
  localparam int CTR_W         = 2;
  localparam int SEL_W         = 10;
  localparam int LEADER_PERIOD = 64;
  localparam int LEADER_BIT    = $clog2(LEADER_PERIOD) - 1;
  localparam int WAY_IDX_W     = 5;
  localparam int VICTIM_W      = 4;

  localparam logic [SEL_W-1:0] SELECTOR_MAX = 10'd1023;
  localparam logic [SEL_W-1:0] SEL_HALF     = SEL_W'(1023 / 2);

  localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;
  localparam logic [RRPV_W-1:0] RRPV_LONG    = 2'd2;
  localparam logic [RRPV_W-1:0] RRPV_NEAR    = 2'd0;

  localparam logic [CTR_W-1:0] CTR_MAX   = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN   = 2'd0;
  localparam logic [CTR_W-1:0] CTR_RESET = 2'd1;
  localparam logic [CTR_W-1:0] CTR_REUSE = 2'd2;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic capture;
    logic wr_back;
    logic load_out;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic is_victim;
    logic out_busy;
    logic clear_last;
  } sts_t;

endpackage

// File: src/rrip_dp.sv
// datapath: row memory, victim search, signature counters, selector, output register
module rrip_dp #(
  parameter int NUM_WAYS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrip_pkg::cmd_t                cmd,
  output rrip_pkg::sts_t                sts,
  input  logic                          op,
  input  logic [rrip_pkg::SET_W-1:0]    set_index,
  input  logic [3:0]                    way_index,
  input  logic [7:0]                    pc_low,
  input  logic                          was_hit,
  output logic                          victim_valid,
  input  logic                          victim_stall,
  output logic [rrip_pkg::VICTIM_W-1:0] victim_way
);

  localparam int ROW_W = NUM_WAYS * rrip_pkg::RRPV_W;
  localparam int WIW   = rrip_pkg::WAY_IDX_W;
  localparam int SW    = rrip_pkg::SET_W;

  logic [ROW_W-1:0] mem [rrip_pkg::NUM_SETS];
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] aged_row;
  logic [ROW_W-1:0] upd_row;
  logic [ROW_W-1:0] mem_wdata;
  logic [SW-1:0]    mem_waddr;
  logic             mem_we;
  logic [SW-1:0]    clr_addr;

  logic                           op_q;
  logic [SW-1:0]                  set_q;
  logic [3:0]                     way_q;
  logic [rrip_pkg::SIG_W-1:0]     sig_q;
  logic                           hit_q;
  logic [7:0]                     sig_mix;

  logic [rrip_pkg::CTR_W-1:0]  sig_ctr [rrip_pkg::SIG_COUNT];
  logic [rrip_pkg::CTR_W-1:0]  ctr_cur;
  logic [rrip_pkg::CTR_W-1:0]  ctr_next;
  logic [rrip_pkg::SEL_W-1:0]  sel;
  logic [rrip_pkg::SEL_W-1:0]  sel_next;
  logic                        srrip_leader;
  logic                        brrip_leader;
  logic                        brrip_pick;
  logic [rrip_pkg::RRPV_W-1:0] ins_val;

  logic                        any3;
  logic                        any2;
  logic                        any1;
  logic [rrip_pkg::RRPV_W-1:0] top;
  logic [rrip_pkg::RRPV_W-1:0] add;
  logic [WIW-1:0]              vidx;

  assign sig_mix = pc_low ^ (pc_low >> 4);

  // capture of the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op;
      set_q <= set_index;
      way_q <= way_index;
      sig_q <= sig_mix[rrip_pkg::SIG_W-1:0];
      hit_q <= was_hit;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign mem_we    = cmd.clear_step | cmd.wr_back;
  assign mem_waddr = cmd.clear_step ? clr_addr : set_q;
  assign mem_wdata = cmd.clear_step ? {NUM_WAYS{rrip_pkg::RRPV_DISTANT}}
                                    : ((op_q == rrip_pkg::OP_VICTIM) ? aged_row : upd_row);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.capture) begin
      rdata <= mem[set_index];
    end
  end

  // largest value in the set and aging
  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any3 = any3 | (rdata[w*rrip_pkg::RRPV_W +: rrip_pkg::RRPV_W] == 2'd3);
      any2 = any2 | (rdata[w*rrip_pkg::RRPV_W +: rrip_pkg::RRPV_W] == 2'd2);
      any1 = any1 | (rdata[w*rrip_pkg::RRPV_W +: rrip_pkg::RRPV_W] == 2'd1);
    end
    if (any3) begin
      top = 2'd3;
    end else if (any2) begin
      top = 2'd2;
    end else if (any1) begin
      top = 2'd1;
    end else begin
      top = 2'd0;
    end
    add = rrip_pkg::RRPV_DISTANT - top;
    vidx = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rdata[w*rrip_pkg::RRPV_W +: rrip_pkg::RRPV_W] == top) begin
        vidx = WIW'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_row[w*rrip_pkg::RRPV_W +: rrip_pkg::RRPV_W] =
        rdata[w*rrip_pkg::RRPV_W +: rrip_pkg::RRPV_W] + add;
    end
  end

  // update path
  always_comb begin
    ctr_cur      = sig_ctr[sig_q];
    srrip_leader = ~set_q[rrip_pkg::LEADER_BIT];
    brrip_leader = set_q[rrip_pkg::LEADER_BIT];
    if (hit_q) begin
      ctr_next = (ctr_cur != rrip_pkg::CTR_MAX) ? ctr_cur + 1'b1 : ctr_cur;
    end else begin
      ctr_next = (ctr_cur != rrip_pkg::CTR_MIN) ? ctr_cur - 1'b1 : ctr_cur;
    end
    if (srrip_leader) begin
      brrip_pick = 1'b0;
    end else if (brrip_leader) begin
      brrip_pick = 1'b1;
    end else begin
      brrip_pick = sel < rrip_pkg::SEL_HALF;
    end
    if (ctr_next >= rrip_pkg::CTR_REUSE) begin
      ins_val = rrip_pkg::RRPV_NEAR;
    end else begin
      ins_val = brrip_pick ? rrip_pkg::RRPV_DISTANT : rrip_pkg::RRPV_LONG;
    end
    sel_next = sel;
    if (hit_q) begin
      if (srrip_leader && (sel != rrip_pkg::SELECTOR_MAX)) begin
        sel_next = sel + 1'b1;
      end else if (brrip_leader && (sel != '0)) begin
        sel_next = sel - 1'b1;
      end
    end
    upd_row = rdata;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WIW'(w) == WIW'(way_q)) begin
        upd_row[w*rrip_pkg::RRPV_W +: rrip_pkg::RRPV_W] = hit_q ? rrip_pkg::RRPV_NEAR
                                                                : ins_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rrip_pkg::SIG_COUNT; i++) begin
        sig_ctr[i] <= rrip_pkg::CTR_RESET;
      end
      sel <= rrip_pkg::SEL_HALF;
    end else if (cmd.wr_back && (op_q == rrip_pkg::OP_UPDATE)) begin
      sig_ctr[sig_q] <= ctr_next;
      sel            <= sel_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      victim_valid <= 1'b0;
    end else if (cmd.load_out) begin
      victim_valid <= 1'b1;
    end else if (victim_valid && !victim_stall) begin
      victim_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      victim_way <= vidx[rrip_pkg::VICTIM_W-1:0];
    end
  end

  assign sts.is_victim  = (op_q == rrip_pkg::OP_VICTIM);
  assign sts.out_busy   = victim_valid & victim_stall;
  assign sts.clear_last = (clr_addr == SW'(rrip_pkg::NUM_SETS - 1));

endmodule

// File: src/rrip_ctrl.sv
// controller state machine of the rrip replacement block
`include "rrip_ship_cache_replacement_macros.svh"

module rrip_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  output rrip_pkg::cmd_t cmd,
  input  rrip_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CALC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CALC;
        end
      end
      ST_CALC: begin
        // a victim result waits for the output register to free up
        if (!(sts.is_victim && sts.out_busy)) begin
          cmd.wr_back  = 1'b1;
          cmd.load_out = sts.is_victim;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign item_stall = (state != ST_IDLE);

  `RRIP_ASSERT(a_capture_to_calc, clk, rst, cmd.capture |=> state == ST_CALC)
  `RRIP_ASSERT(a_clear_done, clk, rst, (state == ST_CLEAR) && sts.clear_last |=> state == ST_IDLE)
  `RRIP_ASSERT(a_no_load_busy, clk, rst, cmd.load_out |-> !sts.out_busy)
  `RRIP_ASSERT(a_calc_holds, clk, rst, (state == ST_CALC) && !cmd.wr_back |=> state == ST_CALC)
  `RRIP_ASSERT_NEVER(a_clear_vs_write, clk, rst, cmd.clear_step && (cmd.wr_back || cmd.capture))

endmodule

// File: src/rrip_ship_cache_replacement.sv
// top level of the rrip replacement policy with signature reuse counters
//
//  channel   signals                                          dir  beat
//  item      item_valid item_stall op set_index way_index     in   one request
//            pc_low was_hit
//  victim    victim_valid victim_stall victim_way             out  one victim way
//
// an item is accepted in the idle state, which reads the set's row from the row
// memory into a register; the compute state then ages or updates the row and
// writes it back through the same single write port
// a victim request that finds the output register still stalled stays in the
// compute cycle until the register frees up; updates give no result beat
// after reset a clearing pass writes all 2048 rows to distant, one row a cycle,
// with item_stall high throughout
// an item may be accepted while a victim beat still waits on victim_stall
module rrip_ship_cache_replacement #(
  parameter int NUM_WAYS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        op,
  input  logic [10:0] set_index,
  input  logic [3:0]  way_index,
  input  logic [7:0]  pc_low,
  input  logic        was_hit,
  output logic        victim_valid,
  input  logic        victim_stall,
  output logic [3:0]  victim_way
);

  // commands from the controller, status back from the datapath
  rrip_pkg::cmd_t cmd;
  rrip_pkg::sts_t sts;

  rrip_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  // row memory holds all ways of one set in one word
  rrip_dp #(
    .NUM_WAYS (NUM_WAYS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op           (op),
    .set_index    (set_index),
    .way_index    (way_index),
    .pc_low       (pc_low),
    .was_hit      (was_hit),
    .victim_valid (victim_valid),
    .victim_stall (victim_stall),
    .victim_way   (victim_way)
  );

endmodule

// File: test/rrip_victim_checker.sv
// watches both channels, predicts victim ways and compares them with the block's beats
`timescale 1ns / 100ps

module rrip_victim_checker
  import rrip_pkg::*;
#(
  parameter int NUM_WAYS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic        op,
  input  logic [10:0] set_index,
  input  logic [3:0]  way_index,
  input  logic [7:0]  pc_low,
  input  logic        was_hit,
  input  logic        victim_valid,
  input  logic        victim_stall,
  input  logic [3:0]  victim_way,
  output int          errors,
  output int          pending
);

  logic [RRPV_W-1:0] rrpv_mem [NUM_SETS][NUM_WAYS];
  logic [CTR_W-1:0]  reuse_ctr [SIG_COUNT];
  logic [SEL_W-1:0]  duel_sel;
  logic [VICTIM_W-1:0] expected_victims [$];
  int err_count = 0;

  // age the set until some way is distant, return the lowest such way
  task automatic age_set(input int s, output logic [VICTIM_W-1:0] way);
    logic [RRPV_W-1:0] top_val;
    int pick;
    top_val = RRPV_NEAR;
    pick = 0;
    for (int w = 0; w < NUM_WAYS; w++)
      if (rrpv_mem[s][w] > top_val) top_val = rrpv_mem[s][w];
    for (int w = NUM_WAYS - 1; w >= 0; w--)
      if (rrpv_mem[s][w] == top_val) pick = w;
    for (int w = 0; w < NUM_WAYS; w++)
      rrpv_mem[s][w] = rrpv_mem[s][w] + (RRPV_DISTANT - top_val);
    way = VICTIM_W'(pick);
  endtask

  // hit promotion or miss insertion, with signature and selector training
  task automatic apply_access(input int s, input int way, input logic [7:0] pc,
                              input logic hit);
    logic [SIG_W-1:0] sig;
    logic sr, br, brrip;
    logic [RRPV_W-1:0] ins;
    sig = SIG_W'(pc ^ (pc >> 4));
    sr = (s % LEADER_PERIOD) < (LEADER_PERIOD / 2);
    br = (s % LEADER_PERIOD) >= (LEADER_PERIOD / 2);
    if (hit) begin
      if (reuse_ctr[sig] != CTR_MAX) reuse_ctr[sig] = reuse_ctr[sig] + 1'b1;
      if (way < NUM_WAYS) rrpv_mem[s][way] = RRPV_NEAR;
      if (sr && duel_sel != SELECTOR_MAX) duel_sel = duel_sel + 1'b1;
      if (br && duel_sel != '0) duel_sel = duel_sel - 1'b1;
    end else begin
      if (reuse_ctr[sig] != CTR_MIN) reuse_ctr[sig] = reuse_ctr[sig] - 1'b1;
      if (sr) brrip = 1'b0;
      else if (br) brrip = 1'b1;
      else brrip = duel_sel < SEL_HALF;
      if (reuse_ctr[sig] >= CTR_REUSE) ins = RRPV_NEAR;
      else ins = brrip ? RRPV_DISTANT : RRPV_LONG;
      if (way < NUM_WAYS) rrpv_mem[s][way] = ins;
    end
  endtask

  always @(posedge clk) begin : watch
    logic [VICTIM_W-1:0] want;
    logic [VICTIM_W-1:0] got;
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++)
        for (int w = 0; w < NUM_WAYS; w++) rrpv_mem[s][w] = RRPV_DISTANT;
      for (int i = 0; i < SIG_COUNT; i++) reuse_ctr[i] = CTR_RESET;
      duel_sel = SEL_HALF;
      expected_victims.delete();
    end else begin
      if (victim_valid && !victim_stall) begin
        if (expected_victims.size() == 0) begin
          $display("%0t: victim beat with none expected, expected none, actual %0d",
                   $time, victim_way);
          err_count++;
        end else begin
          want = expected_victims.pop_front();
          if (victim_way !== want) begin
            $display("%0t: victim_way mismatch, expected %0d, actual %0d",
                     $time, want, victim_way);
            err_count++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (op == OP_VICTIM) begin
          age_set(int'(set_index) % NUM_SETS, got);
          expected_victims.push_back(got);
        end else begin
          apply_access(int'(set_index) % NUM_SETS, int'(way_index), pc_low, was_hit);
        end
      end
    end
    errors  <= err_count;
    pending <= expected_victims.size();
  end

endmodule

// File: test/tb.sv
// stimulus, clock, reset and verdict for the rrip replacement block
`timescale 1ns / 100ps

module tb;
  import rrip_pkg::*;

  localparam int WAYS      = 16;
  localparam int N_RANDOM  = 550;
  localparam int POOL_SIZE = 6;
  // clearing pass plus every item waiting out the longest gap and stall, many times over
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        op = OP_VICTIM;
  logic [10:0] set_index = '0;
  logic [3:0]  way_index = '0;
  logic [7:0]  pc_low = '0;
  logic        was_hit = 1'b0;
  logic        victim_valid;
  logic        victim_stall = 1'b0;
  logic [3:0]  victim_way;

  int fail_count;
  int pending;
  int cycles = 0;
  int n_victim = 0;
  int n_update = 0;
  int n_hit = 0;

  rrip_ship_cache_replacement #(.NUM_WAYS(WAYS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .set_index    (set_index),
    .way_index    (way_index),
    .pc_low       (pc_low),
    .was_hit      (was_hit),
    .victim_valid (victim_valid),
    .victim_stall (victim_stall),
    .victim_way   (victim_way)
  );

  rrip_victim_checker #(.NUM_WAYS(WAYS)) u_victim_chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .set_index    (set_index),
    .way_index    (way_index),
    .pc_low       (pc_low),
    .was_hit      (was_hit),
    .victim_valid (victim_valid),
    .victim_stall (victim_stall),
    .victim_way   (victim_way),
    .errors       (fail_count),
    .pending      (pending)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog, also catches a victim beat that never shows up
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // victim side backpressure: short stalls, a few long ones, and free stretches
  initial begin : stall_gen
    int sel;
    @(posedge clk);
    forever begin
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        // stretch with no stall at all
        victim_stall <= 1'b0;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        victim_stall <= 1'b1;
        repeat ((sel == 9) ? $urandom_range(15, 40) : $urandom_range(1, 3)) @(posedge clk);
        victim_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // present one beat and hold it until the block takes it
  task automatic send_item(input logic o, input logic [10:0] s, input logic [3:0] w,
                           input logic [7:0] pc, input logic h);
    item_valid <= 1'b1;
    op         <= o;
    set_index  <= s;
    way_index  <= w;
    pc_low     <= pc;
    was_hit    <= h;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (o == OP_VICTIM) n_victim++;
    else begin
      n_update++;
      if (h) n_hit++;
    end
  endtask

  // drop valid for a number of cycles, nothing when zero so valid stays high
  task automatic idle_for(input int n);
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // wait until every victim beat has come back, plus the block's own cycles
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin : stim
    logic [10:0] set_pool [POOL_SIZE];
    logic [7:0]  pc_pool [4];
    logic [10:0] s;
    logic [7:0]  pc;
    logic        h;
    int          sent;
    int          r;
    int          gap;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // fresh set, all ways distant, lowest way wins
    send_item(OP_VICTIM, 11'd0, 4'd0, 8'h00, 1'b0);
    idle_for(pick_gap());
    // hit every way of a brrip leader set, pc from 0x00 to 0xff with signature 0
    for (int w = 0; w < WAYS; w++) begin
      send_item(OP_UPDATE, 11'd33, 4'(w), 8'(w * 17), 1'b1);
      idle_for(pick_gap());
    end
    // whole set near: aging adds 3 to every way
    send_item(OP_VICTIM, 11'd33, 4'd0, 8'h00, 1'b0);
    idle_for(pick_gap());
    // miss fill with a reuse-rich signature goes in near
    send_item(OP_UPDATE, 11'd33, 4'd15, 8'h00, 1'b0);
    idle_for(pick_gap());
    // miss fill, weak signature, brrip leader at the top set index
    send_item(OP_UPDATE, 11'd2047, 4'd15, 8'ha5, 1'b0);
    idle_for(pick_gap());
    // miss fill, counter already at zero, srrip leader inserts long
    send_item(OP_UPDATE, 11'd0, 4'd3, 8'h5a, 1'b0);
    idle_for(pick_gap());
    send_item(OP_VICTIM, 11'd0, 4'd0, 8'h00, 1'b0);
    idle_for(pick_gap());
    send_item(OP_UPDATE, 11'd0, 4'd0, 8'h5a, 1'b0);
    idle_for(pick_gap());
    send_item(OP_VICTIM, 11'd0, 4'd0, 8'h00, 1'b0);
    idle_for(pick_gap());
    send_item(OP_VICTIM, 11'd2047, 4'd0, 8'h00, 1'b0);
    drain();

    // ---- random part ----
    sent = 0;
    while (sent < N_RANDOM) begin
      // rotate the hot sets and hot pcs so that rows see many accesses
      if (sent % 100 == 0) begin
        foreach (set_pool[i]) set_pool[i] = 11'($urandom_range(0, NUM_SETS - 1));
        foreach (pc_pool[i]) pc_pool[i] = 8'($urandom_range(0, 255));
      end
      // one or two pauses in the middle until the victim side is empty
      if (sent >= N_RANDOM / 2 && sent < N_RANDOM / 2 + 2) drain();

      r = $urandom_range(0, 99);
      s = (r < 85) ? set_pool[$urandom_range(0, POOL_SIZE - 1)]
                   : 11'($urandom_range(0, NUM_SETS - 1));
      pc = ($urandom_range(0, 9) < 7) ? pc_pool[$urandom_range(0, 3)]
                                      : 8'($urandom_range(0, 255));
      // every fourth stretch of 60 items puts no gap between a victim request and its fill
      gap = (((sent / 60) % 4) == 3) ? 0 : pick_gap();

      r = $urandom_range(0, 99);
      if (r < 40) begin
        // miss sequence: ask for a victim, then fill a way of that set
        send_item(OP_VICTIM, s, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        idle_for(gap);
        send_item(OP_UPDATE, s, 4'($urandom_range(0, 15)), pc, 1'b0);
        sent += 2;
      end else if (r < 85) begin
        // hit on some way of a hot set
        send_item(OP_UPDATE, s, 4'($urandom_range(0, 15)), pc, 1'b1);
        sent += 1;
      end else begin
        // noise: any op, any field
        h = 1'($urandom_range(0, 1));
        send_item(1'($urandom_range(0, 1)), 11'($urandom_range(0, NUM_SETS - 1)),
                  4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), h);
        sent += 1;
      end
      idle_for(pick_gap());
    end

    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d victim requests and %0d updates (%0d hits, %0d miss fills)",
             n_victim, n_update, n_hit, n_update - n_hit);
    $display("hot set pools mixed srrip and brrip leaders, with stalls on both channels");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
